/* hdl/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, character codes and helpers for the format specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int NUMBER_BITS_DEF = 16;

    localparam int IN_DATA_W  = 8;
    localparam int CONV_W     = 4;
    localparam int OUT_NUM_W  = 16;
    localparam int OUT_BITS   = CONV_W + 6 + 2 * OUT_NUM_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Conversion codes
    localparam logic [CONV_W-1:0] CONV_PERCENT = 4'd0;
    localparam logic [CONV_W-1:0] CONV_CHAR    = 4'd1;
    localparam logic [CONV_W-1:0] CONV_STRING  = 4'd2;
    localparam logic [CONV_W-1:0] CONV_DEC_D   = 4'd3;
    localparam logic [CONV_W-1:0] CONV_DEC_I   = 4'd4;
    localparam logic [CONV_W-1:0] CONV_UNSIGN  = 4'd5;
    localparam logic [CONV_W-1:0] CONV_POINTER = 4'd6;
    localparam logic [CONV_W-1:0] CONV_HEX_LO  = 4'd7;
    localparam logic [CONV_W-1:0] CONV_HEX_UP  = 4'd8;
    localparam logic [CONV_W-1:0] CONV_INVALID = 4'd9;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic [OUT_NUM_W-1:0] precision_value;
        logic [OUT_NUM_W-1:0] field_width;
        logic                 plus_sign;
        logic                 space_sign;
        logic                 alternate_form;
        logic                 has_precision;
        logic                 zero_pad;
        logic                 left_justify;
        logic [CONV_W-1:0]    conversion;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_scan_out;

    function automatic logic [CONV_W-1:0] conv_code(input logic [7:0] b);
        logic [CONV_W-1:0] c;
        unique case (b)
            CH_PERCENT: c = CONV_PERCENT;
            CH_C:       c = CONV_CHAR;
            CH_S:       c = CONV_STRING;
            CH_D:       c = CONV_DEC_D;
            CH_I:       c = CONV_DEC_I;
            CH_U:       c = CONV_UNSIGN;
            CH_P:       c = CONV_POINTER;
            CH_X_LO:    c = CONV_HEX_LO;
            CH_X_UP:    c = CONV_HEX_UP;
            default:    c = CONV_INVALID;
        endcase
        return c;
    endfunction

endpackage

/* hdl/fsp_accum.sv */
// ----------------------------------------------------------------------------
// fsp_accum
// Saturating decimal accumulator step: acc * 10 + digit, clamped to all ones.
// ----------------------------------------------------------------------------
module fsp_accum
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic [NUMBER_BITS-1:0] i_acc,
    input  logic [3:0]             i_digit,
    output logic [NUMBER_BITS-1:0] o_acc
);

    localparam int WIDE_W = NUMBER_BITS + 4;
    localparam logic [NUMBER_BITS-1:0] LIMIT = {NUMBER_BITS{1'b1}};

    logic [WIDE_W-1:0] w_ext;
    logic [WIDE_W-1:0] w_sum;

    assign w_ext = WIDE_W'(i_acc);
    // times ten as shift-and-add
    assign w_sum = (w_ext << 3) + (w_ext << 1) + WIDE_W'(i_digit);
    assign o_acc = (w_sum > WIDE_W'(LIMIT)) ? LIMIT : w_sum[NUMBER_BITS-1:0];

endmodule

/* hdl/fsp_scan.sv */
// ----------------------------------------------------------------------------
// fsp_scan
// Scan state (mode, flags, width and precision) and its per-byte update.
// ----------------------------------------------------------------------------
module fsp_scan
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic [7:0] i_byte,
    output t_scan_out o_scan
);

    localparam logic [1:0] MODE_FLAGS = 2'd0;
    localparam logic [1:0] MODE_WIDTH = 2'd1;
    localparam logic [1:0] MODE_DOT   = 2'd2;
    localparam logic [1:0] MODE_PREC  = 2'd3;

    localparam int FB_DASH  = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_DOT   = 2;
    localparam int FB_HASH  = 3;
    localparam int FB_SPACE = 4;
    localparam int FB_PLUS  = 5;

    localparam int EXT_W = (NUMBER_BITS > OUT_NUM_W) ? NUMBER_BITS : OUT_NUM_W;
    localparam logic [EXT_W-1:0] OUT_MAX = EXT_W'({OUT_NUM_W{1'b1}});

    logic [1:0]             r_mode,  n_mode;
    logic [5:0]             r_flags, n_flags;
    logic [NUMBER_BITS-1:0] r_wacc,  n_wacc;
    logic [NUMBER_BITS-1:0] r_pacc,  n_pacc;

    logic                   w_digit;
    logic                   w_nonzero;
    logic [3:0]             w_dval;
    logic [NUMBER_BITS-1:0] w_wacc_in, w_pacc_in;
    logic [NUMBER_BITS-1:0] w_wacc_step, w_pacc_step;
    logic [EXT_W-1:0]       w_wext, w_pext;
    logic                   w_emit;
    t_result                w_res;

    assign w_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_nonzero = (i_byte >= CH_ONE)  && (i_byte <= CH_NINE);
    assign w_dval    = i_byte[3:0];

    // a new run starts from zero
    assign w_wacc_in = (r_mode == MODE_WIDTH) ? r_wacc : '0;
    assign w_pacc_in = (r_mode == MODE_PREC)  ? r_pacc : '0;

    fsp_accum #(.NUMBER_BITS(NUMBER_BITS)) u_wacc (
        .i_acc   (w_wacc_in),
        .i_digit (w_dval),
        .o_acc   (w_wacc_step)
    );

    fsp_accum #(.NUMBER_BITS(NUMBER_BITS)) u_pacc (
        .i_acc   (w_pacc_in),
        .i_digit (w_dval),
        .o_acc   (w_pacc_step)
    );

    assign w_wext = EXT_W'(r_wacc);
    assign w_pext = EXT_W'(r_pacc);

    always_comb begin
        w_res.conversion      = conv_code(i_byte);
        w_res.left_justify    = r_flags[FB_DASH];
        w_res.zero_pad        = r_flags[FB_ZERO];
        w_res.has_precision   = r_flags[FB_DOT];
        w_res.alternate_form  = r_flags[FB_HASH];
        w_res.space_sign      = r_flags[FB_SPACE];
        w_res.plus_sign       = r_flags[FB_PLUS];
        w_res.field_width     = (w_wext > OUT_MAX) ? {OUT_NUM_W{1'b1}}
                                                   : w_wext[OUT_NUM_W-1:0];
        w_res.precision_value = (w_pext > OUT_MAX) ? {OUT_NUM_W{1'b1}}
                                                   : w_pext[OUT_NUM_W-1:0];
    end

    always_comb begin
        n_mode  = r_mode;
        n_flags = r_flags;
        n_wacc  = r_wacc;
        n_pacc  = r_pacc;
        w_emit  = 1'b0;
        priority if ((r_mode == MODE_WIDTH) && w_digit) begin
            n_wacc = w_wacc_step;
        end else if ((r_mode == MODE_PREC) && w_digit) begin
            n_pacc = w_pacc_step;
        end else if ((r_mode == MODE_DOT) && w_nonzero) begin
            n_pacc = w_pacc_step;
            n_mode = MODE_PREC;
        end else begin
            // flag scanning
            n_mode = MODE_FLAGS;
            priority if (i_byte == CH_DASH) begin
                n_flags[FB_DASH] = 1'b1;
            end else if (i_byte == CH_ZERO) begin
                n_flags[FB_ZERO] = 1'b1;
            end else if (i_byte == CH_HASH) begin
                n_flags[FB_HASH] = 1'b1;
            end else if (i_byte == CH_SPACE) begin
                n_flags[FB_SPACE] = 1'b1;
            end else if (i_byte == CH_PLUS) begin
                n_flags[FB_PLUS] = 1'b1;
            end else if (i_byte == CH_DOT) begin
                n_flags[FB_DOT] = 1'b1;
                n_mode          = MODE_DOT;
            end else if (w_nonzero) begin
                n_wacc = w_wacc_step;
                n_mode = MODE_WIDTH;
            end else begin
                // terminator: emit and return to reset state
                w_emit  = 1'b1;
                n_flags = '0;
                n_wacc  = '0;
                n_pacc  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FLAGS;
            r_flags <= '0;
            r_wacc  <= '0;
            r_pacc  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_flags <= n_flags;
            r_wacc  <= n_wacc;
            r_pacc  <= n_pacc;
        end
    end

    assign o_scan.emit   = i_step && w_emit;
    assign o_scan.result = w_res;

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scan.emit |=> (r_mode == MODE_FLAGS) && (r_flags == '0)
                        && (r_wacc == '0) && (r_pacc == '0))
        else $error("scan state not cleared after terminator");

    a_dot_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DOT) || (r_mode == MODE_PREC) |-> r_flags[FB_DOT])
        else $error("dot or precision mode without dot flag");

    a_emit_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scan.emit && (r_mode == MODE_WIDTH) |-> !w_digit)
        else $error("terminator taken inside a width run");
`endif

endmodule

/* hdl/format_spec_parser_core.sv */
// ----------------------------------------------------------------------------
// format_spec_parser_core
// Parses the bytes of a format specifier after the percent sign and emits
// one result item per conversion letter or invalid byte.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then moves through
//   the scanner into the result register once that is free, where it can be
//   taken; bytes that do not end a specifier emit nothing.
// Throughput: 1 item per cycle while m_axis_tready keeps the result slot free;
//   scan update: shift-and-add and compare, between input and result registers.
// Reset: i_rst_n is synchronous, active low; it empties both registers and
//   returns the scanner to flag scanning with all flags and counts at zero.
// ----------------------------------------------------------------------------
module format_spec_parser_core
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side: one specifier byte per item
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] input_byte
    // master side: one result per terminating byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] conversion, [4] left_justify, [5] zero_pad, [6] has_precision,
    // [7] alternate_form, [8] space_sign, [9] plus_sign, [25:10] field_width,
    // [41:26] precision_value, [47:42] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_out_valid;
    t_result              r_out_res;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_acc;
    t_scan_out            w_scan;

    // result slot is free when empty or being drained this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // the held byte moves through the scanner once the result slot is free
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    fsp_scan #(.NUMBER_BITS(NUMBER_BITS)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .o_scan  (w_scan)
    );

    // result register: load on a terminator, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_scan.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan.emit) begin
            r_out_res <= w_scan.result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_res);

`ifndef SYNTHESIS
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.emit |-> w_out_free)
        else $error("result register overwritten before taken");

    a_conv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_res.conversion <= CONV_INVALID))
        else $error("conversion code out of range");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams specifier bytes into format_spec_parser_core, predicts each parsed
// specifier in a scan model of its own, and compares every result item field
// by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
    import fsp_pkg::*;

    localparam int unsigned ACC_MAX     = (1 << NUMBER_BITS_DEF) - 1;
    localparam int          QUIET_LIMIT = 500;   // cycles without any handshake
    localparam int          DRAIN_TAIL  = 8;     // idle tail after the last result

    // flag bit positions in the scan model
    localparam int FL_DASH  = 0;
    localparam int FL_ZERO  = 1;
    localparam int FL_DOT   = 2;
    localparam int FL_HASH  = 3;
    localparam int FL_SPACE = 4;
    localparam int FL_PLUS  = 5;

    typedef enum logic [1:0] {SCAN_FLAGS, SCAN_WIDTH, SCAN_DOT, SCAN_PREC} t_scan_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] input_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [3:0] conversion, [4] left_justify, [5] zero_pad, [6] has_precision,
    // [7] alternate_form, [8] space_sign, [9] plus_sign, [25:10] field_width,
    // [41:26] precision_value, [47:42] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // scan model state
    t_scan_mode  scan_mode  = SCAN_FLAGS;
    logic [5:0]  spec_flags = '0;
    int unsigned width_acc  = 0;
    int unsigned prec_acc   = 0;

    t_result     pending_specs[$];
    int          mismatches     = 0;
    int          bytes_sent     = 0;
    bit          gaps_on        = 1'b1;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    format_spec_parser_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------

    // Append one decimal digit and clamp at the accumulator ceiling.
    function automatic int unsigned add_digit(input int unsigned acc, input logic [7:0] b);
        int unsigned v;
        v = acc * 10 + int'(b - CH_ZERO);
        return (v > ACC_MAX) ? ACC_MAX : v;
    endfunction

    function automatic logic [CONV_W-1:0] letter_code(input logic [7:0] b);
        case (b)
            CH_PERCENT: return CONV_PERCENT;
            CH_C:       return CONV_CHAR;
            CH_S:       return CONV_STRING;
            CH_D:       return CONV_DEC_D;
            CH_I:       return CONV_DEC_I;
            CH_U:       return CONV_UNSIGN;
            CH_P:       return CONV_POINTER;
            CH_X_LO:    return CONV_HEX_LO;
            CH_X_UP:    return CONV_HEX_UP;
            default:    return CONV_INVALID;
        endcase
    endfunction

    // Advance the scan model by one accepted byte; queue a specifier when
    // the byte terminates one.
    task automatic scan_byte(input logic [7:0] b);
        logic    digit;
        logic    lead_digit;
        t_result spec;
        digit      = (b >= CH_ZERO) && (b <= CH_NINE);
        lead_digit = (b >= CH_ONE) && (b <= CH_NINE);
        // extend a running number, or start precision right after a dot
        case (scan_mode)
            SCAN_WIDTH: if (digit) begin
                width_acc = add_digit(width_acc, b);
                return;
            end
            SCAN_PREC: if (digit) begin
                prec_acc = add_digit(prec_acc, b);
                return;
            end
            SCAN_DOT: if (lead_digit) begin
                prec_acc  = add_digit(0, b);
                scan_mode = SCAN_PREC;
                return;
            end
            default: ;
        endcase
        // anything else is read as in flag scanning
        scan_mode = SCAN_FLAGS;
        case (b)
            CH_DASH:  spec_flags[FL_DASH]  = 1'b1;
            CH_ZERO:  spec_flags[FL_ZERO]  = 1'b1;
            CH_HASH:  spec_flags[FL_HASH]  = 1'b1;
            CH_SPACE: spec_flags[FL_SPACE] = 1'b1;
            CH_PLUS:  spec_flags[FL_PLUS]  = 1'b1;
            CH_DOT: begin
                spec_flags[FL_DOT] = 1'b1;
                scan_mode          = SCAN_DOT;
            end
            default: if (lead_digit) begin
                width_acc = add_digit(0, b);
                scan_mode = SCAN_WIDTH;
            end else begin
                spec.conversion      = letter_code(b);
                spec.left_justify    = spec_flags[FL_DASH];
                spec.zero_pad        = spec_flags[FL_ZERO];
                spec.has_precision   = spec_flags[FL_DOT];
                spec.alternate_form  = spec_flags[FL_HASH];
                spec.space_sign      = spec_flags[FL_SPACE];
                spec.plus_sign       = spec_flags[FL_PLUS];
                spec.field_width     = OUT_NUM_W'(width_acc);
                spec.precision_value = OUT_NUM_W'(prec_acc);
                pending_specs.push_back(spec);
                spec_flags = '0;
                width_acc  = 0;
                prec_acc   = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] error: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Sample at the rising edge; pop the oldest prediction per result item.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[OUT_BITS-1:0]);
            if (pending_specs.size() == 0) begin
                report_mismatch($sformatf("result 0x%0h with nothing pending", m_axis_tdata));
            end else begin
                want = pending_specs.pop_front();
                check_field("conversion",      16'(got.conversion),     16'(want.conversion));
                check_field("left_justify",    16'(got.left_justify),   16'(want.left_justify));
                check_field("zero_pad",        16'(got.zero_pad),       16'(want.zero_pad));
                check_field("has_precision",   16'(got.has_precision),  16'(want.has_precision));
                check_field("alternate_form",  16'(got.alternate_form), 16'(want.alternate_form));
                check_field("space_sign",      16'(got.space_sign),     16'(want.space_sign));
                check_field("plus_sign",       16'(got.plus_sign),      16'(want.plus_sign));
                check_field("field_width",     got.field_width,         want.field_width);
                check_field("precision_value", got.precision_value,     want.precision_value);
                check_field("pad bits", 16'(m_axis_tdata[OUT_DATA_W-1:OUT_BITS]), 16'd0);
            end
        end
    end

    // Stall the result side now and then, for a random length, while gaps are on.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            hold_left     <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one byte; called and returning at a falling edge. Valid stays
    // high after the item so back-to-back items need no lowering in between.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = s_axis_tvalid && s_axis_tready;
        end
        scan_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string text);
        foreach (text[k]) send_byte(text[k]);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_specs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    function automatic logic [7:0] flag_char(input int unsigned idx);
        case (idx)
            0:       return CH_DASH;
            1:       return CH_ZERO;
            2:       return CH_HASH;
            3:       return CH_SPACE;
            4:       return CH_PLUS;
            default: return CH_DOT;
        endcase
    endfunction

    function automatic logic [7:0] conv_char(input int unsigned idx);
        case (idx)
            0:       return CH_PERCENT;
            1:       return CH_C;
            2:       return CH_S;
            3:       return CH_D;
            4:       return CH_I;
            5:       return CH_U;
            6:       return CH_P;
            7:       return CH_X_LO;
            default: return CH_X_UP;
        endcase
    endfunction

    // A digit run: mostly short, now and then long enough to saturate.
    task automatic send_number();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        send_byte(CH_ONE + 8'($urandom_range(0, 8)));
        repeat (len - 1) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // One well-formed specifier with random content, sometimes ended by an
    // arbitrary byte instead of a conversion letter.
    task automatic send_random_spec();
        repeat ($urandom_range(0, 3)) send_byte(flag_char($urandom_range(0, 5)));
        if ($urandom_range(0, 1)) send_number();
        if ($urandom_range(0, 1)) begin
            send_byte(CH_DOT);
            if ($urandom_range(0, 2) != 0) send_number();
        end
        // trailing flags or a second width run now and then
        if ($urandom_range(0, 5) == 0) send_byte(flag_char($urandom_range(0, 5)));
        if ($urandom_range(0, 7) == 0) send_number();
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte(conv_char($urandom_range(0, 8)));
    endtask

    task automatic send_random_mix(input int stop_at);
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            else
                send_random_spec();
        end
    endtask

    // every conversion letter bare, then NUL as an invalid byte
    task automatic test_conversions();
        for (int k = 0; k < 9; k++) send_byte(conv_char(k));
        send_byte(8'h00);
        wait_drained();
    endtask

    // all six flags, a double dot, and a zero right after a lone dot
    task automatic test_flags();
        send_text("-#+ ..0d");
        wait_drained();
    endtask

    // saturating width, a precision run, ended by the top byte value
    task automatic test_runs();
        send_text("99999.9");
        send_byte(8'hFF);
        wait_drained();
    endtask

    task automatic test_random_gaps();
        send_random_mix(1050);
        wait_drained();
    endtask

    // last part of the run: no idling on either side
    task automatic test_random_steady();
        gaps_on = 1'b0;
        send_random_mix(1375);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_conversions();
        test_flags();
        test_runs();
        test_random_gaps();
        test_random_steady();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
